>>> rtl/dbpq_pkg.sv
// ----------------------------------------------------------------------------
// dbpq_pkg: shared types and constants
// Words, op codes, status codes and helpers for the duration bounded queue.
// ----------------------------------------------------------------------------
package dbpq_pkg;

  localparam int unsigned DefDepth = 64;
  localparam int unsigned CfgIdxW  = 1;

  // Op codes carried in the input word.
  localparam logic [2:0] OpPush  = 3'd0;
  localparam logic [2:0] OpPop   = 3'd1;
  localparam logic [2:0] OpFlush = 3'd2;
  localparam logic [2:0] OpAbort = 3'd3;
  localparam logic [2:0] OpRead  = 3'd4;

  // Status codes carried in the result word.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StWaitKey = 2'd1;
  localparam logic [1:0] StAborted = 2'd2;
  localparam logic [1:0] StEmpty   = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegCapacity = 1'd0;
  localparam logic [CfgIdxW-1:0] RegKeyAware = 1'd1;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] packet_handle;
    logic [23:0] duration_us;
    logic        is_key;
    logic [31:0] serial_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic [23:0] out_duration_us;
    logic        out_is_key;
    logic [31:0] out_serial;
    logic [6:0]  entry_count;
    logic [23:0] total_ms;
    logic [23:0] peak_ms;
    logic [6:0]  peak_count;
    logic        key_dropped;
    logic        discontinuity;
  } out_word_t;

  // One queued descriptor.
  typedef struct packed {
    logic [15:0] handle;
    logic [23:0] dur;
    logic        key;
    logic [31:0] serial;
  } entry_t;

  // Command from the controller to every cell.
  typedef struct packed {
    logic   shift;  // remove at the addressed place, cells above move down
    logic   load;   // cell at the tail takes the new entry
    entry_t data;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DROP,
    S_DIV,
    S_OUT
  } state_e;

endpackage

>>> rtl/duration_bounded_packet_queue.sv
// ----------------------------------------------------------------------------
// duration_bounded_packet_queue: duration bounded packet queue
// Row of descriptor cells with a controller for push, pop, drop and status.
// ----------------------------------------------------------------------------
// One word at a time. A word passes a check state, a divide state and an
// output state; a push also runs the drop state, which handles overflow by
// dropping entries or clearing the queue and then loads the new entry. The
// result sits in an output register, so the next word can be taken while
// the result waits; the word after that stalls until it leaves. The divide
// by 1000 for total_ms is one registered multiply. Entries live in a row of
// cells; a removal shifts all cells above it down together.
module duration_bounded_packet_queue
  import dbpq_pkg::*;
#(
  parameter int unsigned Depth = DefDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_data_o
);

  localparam int unsigned IdxW = $clog2(Depth);

  entry_t          entries [Depth];
  cell_cmd_t       cmd;
  logic [IdxW-1:0] rm_idx, tail;

  dbpq_ctrl #(.Depth(Depth)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .entries_i(entries), .cmd_o(cmd), .rm_idx_o(rm_idx), .tail_o(tail)
  );

  // Row of cells; the top one takes its own value on a shift.
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    dbpq_cell u_cell (
      .clk_i,
      .cmd_i(cmd),
      .at_or_above_i(IdxW'(g) >= rm_idx),
      .is_tail_i(IdxW'(g) == tail),
      .upper_i(entries[(g + 1 < Depth) ? g + 1 : g]),
      .entry_o(entries[g])
    );
  end

endmodule

>>> rtl/dbpq_cell.sv
// ----------------------------------------------------------------------------
// dbpq_cell: one slot of the queue
// Holds one entry and takes its upper neighbor's entry on a removal at or below it.
// ----------------------------------------------------------------------------
module dbpq_cell
  import dbpq_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      at_or_above_i,  // this slot is at or above the removed one
  input  logic      is_tail_i,      // this slot is the first free one
  input  entry_t    upper_i,
  output entry_t    entry_o
);

  entry_t entry_q;

  // Shift down on a removal, or take the new entry at the tail.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift && at_or_above_i) begin
      entry_q <= upper_i;
    end else if (cmd_i.load && is_tail_i) begin
      entry_q <= cmd_i.data;
    end
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/dbpq_ctrl.sv
// ----------------------------------------------------------------------------
// dbpq_ctrl: queue controller
// Runs each operation, the drop loop and the divide by 1000 for the output.
// ----------------------------------------------------------------------------
module dbpq_ctrl
  import dbpq_pkg::*;
#(
  parameter int unsigned Depth = DefDepth,
  localparam int unsigned IdxW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_word_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_word_t        out_data_o,
  input  entry_t           entries_i [Depth],
  output cell_cmd_t        cmd_o,
  output logic [IdxW-1:0]  rm_idx_o,
  output logic [IdxW-1:0]  tail_o
);

  // Reciprocal of 125 scaled by 2^37 and rounded up. For any value below 2^30
  // the product shifted right by 37 equals the value divided by 125.
  localparam logic [30:0] Recip125 = 31'd1099511628;

  state_e      state_q, state_d;
  logic [31:0] cap_q;
  logic        aware_q;
  in_word_t    req_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [32:0] tot_q, tot_d;
  logic [23:0] pk_ms_q, pk_ms_d;
  logic [CntW-1:0] pk_cnt_q, pk_cnt_d;
  logic        wait_q, wait_d, abort_q, abort_d, kd_q, kd_d, dc_q, dc_d;
  out_word_t   res_q, res_d;
  out_word_t   out_q, out_d;
  logic        out_vld_q, out_vld_d;
  logic [42:0] capx;
  logic        ovf;
  logic [60:0] prod_q, prod_d;
  logic        pushed_q, pushed_d;
  logic [IdxW-1:0] first_nk;
  logic        any_nk;
  logic [23:0] tot_ms;

  assign capx = {11'd0, cap_q} * 43'd1000;
  assign ovf  = (cnt_q != '0) &&
                ((cnt_q >= CntW'(Depth)) ||
                 ({10'd0, tot_q} + {19'd0, req_q.duration_us} > capx));

  // Oldest non-key entry among the queued ones.
  always_comb begin
    first_nk = '0;
    any_nk   = 1'b0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if ((CntW'(i) < cnt_q) && !entries_i[i].key) begin
        first_nk = IdxW'(i);
        any_nk   = 1'b1;
      end
    end
  end

  // The quotient never exceeds 24 bits, since the total is below 2^33.
  assign tot_ms = prod_q[60:37];
  assign tail_o = cnt_q[IdxW-1:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= 32'd1000000;
      aware_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegCapacity) cap_q <= cfg_data_i;
      if (cfg_idx_i == RegKeyAware) aware_q <= cfg_data_i[0];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      tot_q     <= '0;
      pk_ms_q   <= '0;
      pk_cnt_q  <= '0;
      wait_q    <= 1'b0;
      abort_q   <= 1'b0;
      kd_q      <= 1'b0;
      dc_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      tot_q     <= tot_d;
      pk_ms_q   <= pk_ms_d;
      pk_cnt_q  <= pk_cnt_d;
      wait_q    <= wait_d;
      abort_q   <= abort_d;
      kd_q      <= kd_d;
      dc_q      <= dc_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    res_q    <= res_d;
    out_q    <= out_d;
    prod_q   <= prod_d;
    pushed_q <= pushed_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Next state, queue bookkeeping and cell commands.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    tot_d     = tot_q;
    pk_ms_d   = pk_ms_q;
    pk_cnt_d  = pk_cnt_q;
    wait_d    = wait_q;
    abort_d   = abort_q;
    kd_d      = kd_q;
    dc_d      = dc_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    prod_d    = prod_q;
    pushed_d  = pushed_q;
    cmd_o    = '{shift: 1'b0, load: 1'b0,
                 data: '{handle: req_q.packet_handle, dur: req_q.duration_us,
                         key: req_q.is_key, serial: req_q.serial_in}};
    rm_idx_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d  = S_CHECK;
          res_d    = '0;
          pushed_d = 1'b0;
        end
      end
      S_CHECK: begin
        state_d = S_DIV;
        case (req_q.op)
          OpPush: begin
            if (aware_q && wait_q && !req_q.is_key) begin
              res_d.status = StWaitKey;
            end else begin
              if (aware_q && wait_q) wait_d = 1'b0;
              state_d = S_DROP;
            end
          end
          OpPop: begin
            if (abort_q) begin
              res_d.status = StAborted;
            end else if (cnt_q == '0) begin
              res_d.status = StEmpty;
            end else begin
              res_d.out_handle      = entries_i[0].handle;
              res_d.out_duration_us = entries_i[0].dur;
              res_d.out_is_key      = entries_i[0].key;
              res_d.out_serial      = entries_i[0].serial;
              cmd_o.shift = 1'b1;
              cnt_d = cnt_q - 1'b1;
              tot_d = tot_q - {9'd0, entries_i[0].dur};
            end
          end
          OpFlush: begin
            cnt_d = '0; tot_d = '0; pk_ms_d = '0; pk_cnt_d = '0;
            abort_d = 1'b0; wait_d = 1'b0; dc_d = 1'b0;
          end
          OpAbort: abort_d = 1'b1;
          default: ;
        endcase
      end
      S_DROP: begin
        // One overflow step per cycle: drop one entry or clear all, then push unless aborted or waiting for a keyframe.
        if (ovf) begin
          if (abort_q) begin
            res_d.status = StAborted;
            state_d = S_DIV;
          end else if (aware_q) begin
            cnt_d = '0;
            tot_d = '0;
            dc_d  = 1'b1;
            if (!req_q.is_key) begin
              wait_d = 1'b1;
              res_d.status = StWaitKey;
              state_d = S_DIV;
            end
          end else begin
            cmd_o.shift = 1'b1;
            rm_idx_o = any_nk ? first_nk : '0;
            if (!any_nk) kd_d = 1'b1;
            cnt_d = cnt_q - 1'b1;
            tot_d = tot_q - {9'd0, entries_i[rm_idx_o].dur};
          end
        end else begin
          cmd_o.load = 1'b1;
          cnt_d = cnt_q + 1'b1;
          tot_d = tot_q + {9'd0, req_q.duration_us};
          pushed_d = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // Total / 1000 is (total / 8) / 125; the product is registered here.
        prod_d  = {31'd0, tot_q[32:3]} * {30'd0, Recip125};
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hand the result over once the output register is free or emptying.
        if (!out_vld_q || out_ready_i) begin
          out_d             = res_q;
          out_d.entry_count = 7'(cnt_q);
          out_d.total_ms    = tot_ms;
          if (pushed_q) begin
            pushed_d = 1'b0;
            if (tot_ms > pk_ms_q) pk_ms_d = tot_ms;
            if (cnt_q > pk_cnt_q) pk_cnt_d = cnt_q;
            out_d.peak_ms    = (tot_ms > pk_ms_q) ? tot_ms : pk_ms_q;
            out_d.peak_count = 7'((cnt_q > pk_cnt_q) ? cnt_q : pk_cnt_q);
          end else begin
            out_d.peak_ms    = pk_ms_q;
            out_d.peak_count = 7'(pk_cnt_q);
          end
          out_d.key_dropped   = kd_q;
          out_d.discontinuity = dc_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
          if (req_q.op == OpRead) begin
            pk_ms_d = '0; pk_cnt_d = '0; kd_d = 1'b0; dc_d = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> rtl/dbpq_checker.sv
// ----------------------------------------------------------------------------
// dbpq_checker: port level checks
// Watches the handshakes and result words of the queue.
// ----------------------------------------------------------------------------
module dbpq_checker
  import dbpq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // A pending result holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // The block is busy in the cycle after it takes a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // The popped handle is zero unless the status is ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |-> out_data_o.out_handle == '0)
    else $error("handle set on failed operation");

  // An empty-queue status always reports zero entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StEmpty |-> out_data_o.entry_count == '0)
    else $error("empty status with entries queued");

endmodule

bind duration_bounded_packet_queue dbpq_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

>>> dv/duration_bounded_packet_queue_test.sv
// ----------------------------------------------------------------------------
// duration_bounded_packet_queue_test: self-checking bench for the packet queue
// Drives push, pop, flush, abort, status and unused op words in both overflow modes and
// compares every result word with a behavioral queue kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module duration_bounded_packet_queue_test;
  import dbpq_pkg::*;

  localparam int unsigned QDepth = DefDepth;
  localparam int unsigned CycleLimit = 3000000;

  // Behavioral queue and result checker.
  class queue_scoreboard;
    entry_t      slots[$];
    logic [32:0] total_us;
    logic [23:0] peak_ms;
    logic [6:0]  peak_cnt;
    bit          wait_key, aborted, key_drop, discont;
    logic [31:0] cap_us;
    bit          key_aware;
    out_word_t   pending[$];
    int          mismatches;
    int          checked;

    function new();
      cap_us = 32'd1000000;
      key_aware = 0;
      total_us = '0;
      peak_ms = '0;
      peak_cnt = '0;
    endfunction

    function logic [23:0] to_ms(logic [32:0] us);
      logic [32:0] ms;
      ms = us / 1000;
      return (ms > 33'hFFFFFF) ? 24'hFFFFFF : ms[23:0];
    endfunction

    function bit over(logic [23:0] dur);
      if (slots.size() == 0) return 0;
      if (slots.size() >= QDepth) return 1;
      return ({10'd0, total_us} + {19'd0, dur}) > ({11'd0, cap_us} * 43'd1000);
    endfunction

    function void drop_at(int idx);
      total_us = total_us - {9'd0, slots[idx].dur};
      slots.delete(idx);
    endfunction

    function logic [1:0] push(in_word_t w);
      entry_t e;
      int     idx;
      logic [23:0] ms;
      if (key_aware && wait_key) begin
        if (!w.is_key) return StWaitKey;
        wait_key = 0;
      end
      while (over(w.duration_us)) begin
        if (aborted) return StAborted;
        if (key_aware) begin
          slots.delete();
          total_us = '0;
          discont = 1;
          if (!w.is_key) begin
            wait_key = 1;
            return StWaitKey;
          end
          break;
        end
        idx = -1;
        foreach (slots[i]) if (idx < 0 && !slots[i].key) idx = i;
        if (idx < 0) begin
          idx = 0;
          key_drop = 1;
        end
        drop_at(idx);
      end
      e.handle = w.packet_handle;
      e.dur = w.duration_us;
      e.key = w.is_key;
      e.serial = w.serial_in;
      slots.insert(slots.size(), e);
      total_us = total_us + {9'd0, w.duration_us};
      ms = to_ms(total_us);
      if (ms > peak_ms) peak_ms = ms;
      if (slots.size() > peak_cnt) peak_cnt = 7'(slots.size());
      return StOk;
    endfunction

    // Notes an accepted input word and queues its expected result.
    function void note_word(in_word_t w);
      out_word_t r;
      r = '0;
      r.status = StOk;
      case (w.op)
        OpPush: r.status = push(w);
        OpPop: begin
          if (aborted) r.status = StAborted;
          else if (slots.size() == 0) r.status = StEmpty;
          else begin
            r.out_handle = slots[0].handle;
            r.out_duration_us = slots[0].dur;
            r.out_is_key = slots[0].key;
            r.out_serial = slots[0].serial;
            drop_at(0);
          end
        end
        OpFlush: begin
          slots.delete();
          total_us = '0;
          peak_ms = '0;
          peak_cnt = '0;
          aborted = 0;
          wait_key = 0;
          discont = 0;
        end
        OpAbort: aborted = 1;
        default: ;
      endcase
      r.entry_count = 7'(slots.size());
      r.total_ms = to_ms(total_us);
      r.peak_ms = peak_ms;
      r.peak_count = peak_cnt;
      r.key_dropped = key_drop;
      r.discontinuity = discont;
      if (w.op == OpRead) begin
        peak_ms = '0;
        peak_cnt = '0;
        key_drop = 0;
        discont = 0;
      end
      pending.insert(pending.size(), r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= 40)
        $display("MISMATCH word %0d %s: got %0h want %0h", checked, what, got, want);
    endtask

    // Checks one result word against the oldest expectation.
    task check_word(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
        return;
      end
      e = pending[0];
      pending.delete(0);
      checked++;
      if (got.status != e.status) report_mismatch("status", got.status, e.status);
      if (got.out_handle != e.out_handle)
        report_mismatch("out_handle", got.out_handle, e.out_handle);
      if (got.out_duration_us != e.out_duration_us)
        report_mismatch("out_duration_us", got.out_duration_us, e.out_duration_us);
      if (got.out_is_key != e.out_is_key)
        report_mismatch("out_is_key", got.out_is_key, e.out_is_key);
      if (got.out_serial != e.out_serial)
        report_mismatch("out_serial", got.out_serial, e.out_serial);
      if (got.entry_count != e.entry_count)
        report_mismatch("entry_count", got.entry_count, e.entry_count);
      if (got.total_ms != e.total_ms) report_mismatch("total_ms", got.total_ms, e.total_ms);
      if (got.peak_ms != e.peak_ms) report_mismatch("peak_ms", got.peak_ms, e.peak_ms);
      if (got.peak_count != e.peak_count)
        report_mismatch("peak_count", got.peak_count, e.peak_count);
      if (got.key_dropped != e.key_dropped)
        report_mismatch("key_dropped", got.key_dropped, e.key_dropped);
      if (got.discontinuity != e.discontinuity)
        report_mismatch("discontinuity", got.discontinuity, e.discontinuity);
    endtask
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic      in_valid_i = 0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 0;
  out_word_t out_data_o;

  queue_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 0;
  int  cycles = 0;
  int  words_sent = 0;

  always #5 clk_i = ~clk_i;

  duration_bounded_packet_queue DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_word(out_data_o);
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one word, with random idle cycles before it. Valid stays high after
  // acceptance until the next word or an idle cycle replaces it.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    wait_drained();
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == RegCapacity) sb.cap_us = val;
    else sb.key_aware = val[0];
  endtask

  function automatic in_word_t make_word(logic [2:0] op, logic [23:0] dur, bit key);
    in_word_t w;
    w.op = op;
    w.packet_handle = 16'($urandom);
    w.duration_us = dur;
    w.is_key = key;
    w.serial_in = $urandom;
    return w;
  endfunction

  // Random word: mostly pushes and pops, durations zero, full range or up to 400000 us.
  function automatic in_word_t rand_word();
    int r;
    logic [2:0] op;
    logic [23:0] dur;
    r = $urandom_range(99);
    if (r < 55) op = OpPush;
    else if (r < 85) op = OpPop;
    else if (r < 89) op = OpFlush;
    else if (r < 91) op = OpAbort;
    else if (r < 97) op = OpRead;
    else op = 3'($urandom_range(7, 5));
    case ($urandom_range(9))
      0: dur = 24'($urandom);
      1: dur = 24'hFFFFFF;
      2: dur = 0;
      default: dur = 24'($urandom_range(400000));
    endcase
    return make_word(op, dur, $urandom_range(3) == 0);
  endfunction

  task automatic run_random(int n);
    repeat (n) send_word(rand_word());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: every op, field extremes, empty pop, abort paths, status read.
    send_word(make_word(OpPop, 0, 0));
    send_word(make_word(OpPush, 24'hFFFFFF, 1));
    send_word(make_word(OpPush, 0, 0));
    send_word(make_word(OpPush, 24'hFFFFFF, 0));
    send_word(make_word(OpRead, 0, 0));
    send_word(make_word(OpAbort, 0, 0));
    send_word(make_word(OpPush, 24'hFFFFFF, 1));
    send_word(make_word(OpPush, 1, 0));
    send_word(make_word(OpPop, 0, 0));
    send_word(make_word(OpFlush, 0, 0));
    send_word(make_word(3'd5, 0, 0));
    send_word(make_word(3'd7, 24'hFFFFFF, 1));
    send_word(make_word(OpPop, 0, 0));

    // Keyframe-aware mode with a tiny capacity: discontinuity and key wait.
    write_reg(RegKeyAware, 1);
    write_reg(RegCapacity, 32'd1);
    send_word(make_word(OpPush, 600, 1));
    send_word(make_word(OpPush, 600, 0));
    send_word(make_word(OpPush, 10, 0));
    send_word(make_word(OpPush, 10, 1));
    send_word(make_word(OpRead, 0, 0));
    send_word(make_word(OpPop, 0, 0));

    // Drop-oldest mode, key-only queue forces a key drop.
    write_reg(RegKeyAware, 0);
    send_word(make_word(OpPush, 600, 1));
    send_word(make_word(OpPush, 600, 1));
    send_word(make_word(OpRead, 0, 0));
    send_word(make_word(OpFlush, 0, 0));

    // Fill the store past its depth while the receiver holds off.
    write_reg(RegCapacity, 32'hFFFFFFFF);
    recv_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        recv_hold = 0;
      end
      repeat (QDepth + 6)
        send_word(make_word(OpPush, 24'($urandom), 1'($urandom_range(1))));
    join
    wait_drained();

    // Random phases across settings and idling profiles.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: write_reg(RegCapacity, 32'd1000);
        1: write_reg(RegCapacity, 32'd0);
        2: write_reg(RegCapacity, $urandom_range(3000, 200));
        default: write_reg(RegCapacity, 32'hFFFFFFFF);
      endcase
      write_reg(RegKeyAware, ph[0]);
      send_idle_pct = (ph < 3) ? 6 : (ph < 6) ? 60 : 0;
      recv_idle_pct = (ph < 3) ? 60 : (ph < 6) ? 6 : 0;
      run_random(100);
    end

    wait_drained();
    $display("Sent %0d words, checked %0d results over both overflow modes,",
             words_sent, sb.checked);
    $display("capacities from zero to full range, with stalls and a full store.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dbpq_pkg.sv
rtl/dbpq_cell.sv
rtl/dbpq_ctrl.sv
rtl/duration_bounded_packet_queue.sv
rtl/dbpq_checker.sv
dv/duration_bounded_packet_queue_test.sv
